>>> hdl/tce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types, constants and saturation helpers for the tricorn escape-time
// block.
// ----------------------------------------------------------------------------
package tce_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 28;
	localparam int CNT_W      = 16;
	localparam int PROD_W     = 2 * DATA_WIDTH;
	localparam int SUM_W      = DATA_WIDTH + 1;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	typedef logic signed [DATA_WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0]             cnt_t;

	localparam word_t WMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam word_t WMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	// 4.0 in the word format, or the largest word when 4.0 does not fit
	localparam word_t FOUR = (FRAC_BITS + 4 <= DATA_WIDTH) ?
		word_t'(64'd1 << (FRAC_BITS + 2)) : WMAX;

	localparam cnt_t MAX_ITER_RST = cnt_t'(255);

	// one queued job
	typedef struct packed {
		word_t c_real;
		word_t c_imag;
		cnt_t  limit;
		logic  trivial;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic busy;
	} bk_stat_t;

	function automatic word_t sat_prod(input logic signed [PROD_W-1:0] v);
		logic fits;
		fits = (&v[PROD_W-1:DATA_WIDTH-1]) | ~(|v[PROD_W-1:DATA_WIDTH-1]);
		if (fits)
			return v[DATA_WIDTH-1:0];
		else if (v[PROD_W-1])
			return WMIN;
		else
			return WMAX;
	endfunction

	function automatic word_t sat_sum(input logic signed [SUM_W-1:0] v);
		if (v[SUM_W-1] == v[SUM_W-2])
			return v[DATA_WIDTH-1:0];
		else if (v[SUM_W-1])
			return WMIN;
		else
			return WMAX;
	endfunction

endpackage

>>> hdl/tce_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_front
// Input stage: holds the limit register, takes points and tags each job
// with its limit and a flag for the no-iteration case.
// ----------------------------------------------------------------------------
module tce_front import tce_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  word_t c_real,
	input  word_t c_imag,
	input  logic  cfg_valid,
	output logic  cfg_ready,
	input  cnt_t  cfg_data,
	output logic  job_valid,
	output job_t  job,
	input  logic  job_ready
);

	cnt_t max_iter_q;
	logic valid_q;
	job_t job_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !valid_q || job_ready;
	assign job_valid = valid_q;
	assign job       = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= MAX_ITER_RST;
			valid_q    <= 1'b0;
		end else begin
			if (cfg_valid)
				max_iter_q <= cfg_data;
			if (in_valid && in_ready)
				valid_q <= 1'b1;
			else if (job_ready)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			job_q.c_real  <= c_real;
			job_q.c_imag  <= c_imag;
			job_q.limit   <= max_iter_q;
			job_q.trivial <= (max_iter_q == '0);
		end
	end

endmodule

>>> hdl/tce_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_queue
// Short job queue between the input stage and the iteration engine.
// ----------------------------------------------------------------------------
module tce_queue import tce_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	output logic    push_ready,
	input  job_t    push_job,
	output logic    pop_valid,
	input  logic    pop_ready,
	output job_t    pop_job,
	output q_stat_t stat
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign stat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign push_ready = !stat.full;
	assign pop_valid  = !stat.empty;
	assign pop_job    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

endmodule

>>> hdl/tce_iter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_iter
// Iteration engine: multiply step then update step per iteration of
// z <- conj(z)^2 + c, with the word result held in an output register.
// ----------------------------------------------------------------------------
module tce_iter import tce_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     job_valid,
	output logic     job_ready,
	input  job_t     job,
	output logic     out_valid,
	input  logic     out_ready,
	output cnt_t     iteration_count,
	output logic     escaped,
	output bk_stat_t stat
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	word_t      x_q, y_q, cr_q, ci_q;
	cnt_t       cnt_q, limit_q;
	logic       esc_q;
	logic       out_valid_q;
	cnt_t       out_cnt_q;
	logic       out_esc_q;

	logic signed [PROD_W-1:0] pxx_s1, pyy_s1, pxy_s1;
	logic signed [PROD_W-1:0] pxx_d, pyy_d, pxy_d;

	word_t xx, yy, t, mag, dxy, negt, nx, ny;
	logic  esc_now;
	logic  out_load;

	assign pxx_d = PROD_W'(x_q) * PROD_W'(x_q);
	assign pyy_d = PROD_W'(y_q) * PROD_W'(y_q);
	assign pxy_d = PROD_W'(x_q) * PROD_W'(y_q);

	// floor shift, then clamp to the word
	assign xx      = sat_prod(pxx_s1 >>> FRAC_BITS);
	assign yy      = sat_prod(pyy_s1 >>> FRAC_BITS);
	assign t       = sat_prod(pxy_s1 >>> (FRAC_BITS - 1));
	assign mag     = sat_sum(SUM_W'(xx) + SUM_W'(yy));
	assign esc_now = (mag >= FOUR);
	assign dxy     = sat_sum(SUM_W'(xx) - SUM_W'(yy));
	assign nx      = sat_sum(SUM_W'(dxy) + SUM_W'(cr_q));
	assign negt    = (t == WMIN) ? WMAX : -t;
	assign ny      = sat_sum(SUM_W'(negt) + SUM_W'(ci_q));

	assign job_ready       = (state_q == ST_IDLE);
	assign out_load        = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid       = out_valid_q;
	assign iteration_count = out_cnt_q;
	assign escaped         = out_esc_q;
	assign stat.busy       = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (job_valid)
						state_q <= job.trivial ? ST_DONE : ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (esc_now || (cnt_q >= limit_q))
						state_q <= ST_DONE;
					else
						state_q <= ST_MUL;
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			pxx_s1 <= pxx_d;
			pyy_s1 <= pyy_d;
			pxy_s1 <= pxy_d;
		end
		if (out_load) begin
			out_cnt_q <= cnt_q;
			out_esc_q <= esc_q;
		end
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					cr_q    <= job.c_real;
					ci_q    <= job.c_imag;
					limit_q <= job.limit;
					x_q     <= '0;
					y_q     <= '0;
					cnt_q   <= '0;
					esc_q   <= 1'b0;
				end
			end
			ST_UPD: begin
				if (esc_now) begin
					esc_q <= 1'b1;
				end else if (cnt_q < limit_q) begin
					x_q   <= nx;
					y_q   <= ny;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> hdl/tricorn_escape_time.sv
`timescale 1ns / 1ps
// A point passes the input register, the job queue and the iteration engine,
// whose output register holds the result word; each iteration is a multiply
// step and an update step in the single iteration engine.
// The engine takes a new point only once it has finished the last one, so
// points are computed one at a time while the queue holds those waiting.
// Reset: arst_n clears all handshake and control state; max_iterations is 255.
// ----------------------------------------------------------------------------
// tricorn_escape_time
// Escape-time count for one point of the tricorn fractal in signed fixed
// point: input stage, job queue and iteration engine.
// ----------------------------------------------------------------------------
module tricorn_escape_time import tce_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  word_t c_real,
	input  word_t c_imag,
	output logic  out_valid,
	input  logic  out_ready,
	output cnt_t  iteration_count,
	output logic  escaped,
	input  logic  cfg_valid,
	output logic  cfg_ready,
	input  cnt_t  cfg_data
);

	logic     f_valid, f_ready;
	job_t     f_job;
	logic     q_valid, q_ready;
	job_t     q_job;
	q_stat_t  q_stat;
	bk_stat_t bk_stat;

	tce_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.c_real    (c_real),
		.c_imag    (c_imag),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.job_valid (f_valid),
		.job       (f_job),
		.job_ready (f_ready)
	);

	tce_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_job   (f_job),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_job    (q_job),
		.stat       (q_stat)
	);

	tce_iter u_iter (
		.clk             (clk),
		.arst_n          (arst_n),
		.job_valid       (q_valid),
		.job_ready       (q_ready),
		.job             (q_job),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.iteration_count (iteration_count),
		.escaped         (escaped),
		.stat            (bk_stat)
	);

`ifndef SYNTHESIS
	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty at once");

	// z starts at zero, so no point can escape before its first iteration
	a_esc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && escaped) |-> (iteration_count != '0))
		else $error("escaped word with zero count");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(bk_stat.busy))
		else $error("result word without engine activity");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |=> (bk_stat.busy || $past(q_job.trivial) == 1'b0))
		else $error("job taken but engine not started");
`endif

endmodule

>>> bench/tricorn_escape_time_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tricorn_escape_time_tb
// Self-checking bench for the tricorn escape-time block. Points go in through
// the input channel, an escape-count predictor in the scoreboard computes each
// expected count and flag, and result words are checked in order. The limit
// register is rewritten between phases, including 0, 1 and 65535.
// ----------------------------------------------------------------------------
module tricorn_escape_time_tb;
	import tce_pkg::*;

	localparam word_t ONE         = word_t'(64'd1 << FRAC_BITS);
	localparam int    STALL_LIMIT = 600000;

	typedef struct packed {
		cnt_t count;
		logic escaped;
	} verdict_t;

	// scoreboard: predicts each point's escape count, checks result words
	class escape_board;
		cnt_t     limit;
		verdict_t awaited[$];
		int       points;
		int       escapes;
		int       mismatches;

		function new();
			limit = MAX_ITER_RST;
			points = 0;
			escapes = 0;
			mismatches = 0;
		endfunction

		function word_t fit_word(logic signed [127:0] v);
			if (v > WMAX)
				return WMAX;
			if (v < WMIN)
				return WMIN;
			return word_t'(v);
		endfunction

		// exact product, floor shift, then clamp to the word
		function word_t mul_floor(word_t a, word_t b, int sh);
			logic signed [127:0] p;
			p = a;
			p = p * b;
			return fit_word(p >>> sh);
		endfunction

		function word_t add_sat(word_t a, word_t b);
			logic signed [127:0] s;
			s = a;
			s = s + b;
			return fit_word(s);
		endfunction

		function word_t neg_sat(word_t a);
			if (a == WMIN)
				return WMAX;
			return -a;
		endfunction

		function verdict_t predict_escape(word_t cr, word_t ci);
			word_t    x;
			word_t    y;
			word_t    xx;
			word_t    yy;
			word_t    txy;
			word_t    nx;
			int       n;
			logic     done;
			verdict_t v;
			x = '0;
			y = '0;
			n = 0;
			done = 1'b0;
			v.escaped = 1'b0;
			while (!done) begin
				xx = mul_floor(x, x, FRAC_BITS);
				yy = mul_floor(y, y, FRAC_BITS);
				if (add_sat(xx, yy) >= FOUR) begin
					v.escaped = 1'b1;
					done = 1'b1;
				end else if (n >= limit) begin
					done = 1'b1;
				end else begin
					// 2*x*y comes from one less shift
					txy = mul_floor(x, y, FRAC_BITS - 1);
					nx = add_sat(add_sat(xx, neg_sat(yy)), cr);
					y = add_sat(neg_sat(txy), ci);
					x = nx;
					n++;
				end
			end
			v.count = cnt_t'(n);
			return v;
		endfunction

		function void note_point(word_t cr, word_t ci);
			verdict_t v;
			v = predict_escape(cr, ci);
			if (v.escaped)
				escapes++;
			points++;
			awaited.push_back(v);
		endfunction

		function void check_result(cnt_t count, logic esc);
			verdict_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: count %0d escaped %0b", count, esc);
				return;
			end
			want = awaited.pop_front();
			if (want.count !== count || want.escaped !== esc) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: count exp %0d got %0d, escaped exp %0b got %0b",
						want.count, count, want.escaped, esc);
			end
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	word_t c_real;
	word_t c_imag;
	logic  out_valid;
	logic  out_ready = 1'b0;
	cnt_t  iteration_count;
	logic  escaped;
	logic  cfg_valid;
	logic  cfg_ready;
	cnt_t  cfg_data;

	logic        no_gaps = 1'b0;
	int          stall_cycles = 0;
	int          limit_writes = 0;
	escape_board board = new();

	tricorn_escape_time dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.c_real         (c_real),
		.c_imag         (c_imag),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.iteration_count(iteration_count),
		.escaped        (escaped),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver stalls
	always @(negedge clk) begin
		out_ready = no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 31);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(iteration_count, escaped);
	end

	// watchdog on cycles with no word moving on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_point(input word_t re, input word_t im);
		@(negedge clk);
		while (!no_gaps && $urandom_range(0, 99) < 31) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		c_real = re;
		c_imag = im;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_point(re, im);
	endtask

	// drain everything in flight, then write the limit register
	task automatic write_limit(input cnt_t value);
		@(negedge clk);
		in_valid = 1'b0;
		while (board.awaited.size() != 0)
			@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		do
			@(posedge clk);
		while (!cfg_ready);
		board.limit = value;
		limit_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// point with |c_real| of 2.5 or more: escapes after one iteration
	task automatic send_far_point();
		word_t re;
		re = word_t'($urandom_range(0, 32'd1342177280)) + ONE * 5 / 2;
		if ($urandom_range(0, 1))
			re = -re;
		send_point(re, word_t'($urandom));
	endtask

	initial begin
		word_t re;
		word_t im;
		arst_n = 1'b0;
		in_valid = 1'b0;
		c_real = '0;
		c_imag = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed points at the reset limit
		send_point('0, '0);
		send_point(ONE * 2, '0);
		send_point(-(ONE * 2), '0);
		send_point('0, ONE * 2);
		send_point('0, -(ONE * 2));
		send_point(ONE * 2 - 1, '0);
		send_point(WMAX, WMAX);
		send_point(WMIN, WMIN);
		send_point(WMAX, WMIN);
		send_point(WMIN, WMAX);
		send_point(WMIN, '0);
		send_point(word_t'(-1), word_t'(1));
		send_point(word_t'(1), word_t'(-1));
		send_point(-ONE, '0);
		send_point(ONE / 4, '0);
		send_point(ONE, ONE);
		send_point(ONE * 3 / 8, ONE / 2);
		send_point(-(ONE * 3 / 4), ONE / 8);
		send_point(word_t'(-1), word_t'(-1));

		// zero limit: no iteration at all
		write_limit(cnt_t'(0));
		send_point('0, '0);
		send_point(ONE * 2, '0);
		send_point(WMIN, WMAX);
		send_point(word_t'($urandom), word_t'($urandom));

		// limit 1, with limit hit and escape on the same step
		write_limit(cnt_t'(1));
		send_point(ONE * 2, '0);
		send_point('0, -(ONE * 2));
		send_point('0, '0);
		send_point(ONE, ONE);
		send_point(WMAX, WMAX);

		// largest limit: one bounded point, the rest escape early
		write_limit(cnt_t'(16'hFFFF));
		send_point('0, '0);
		repeat (4)
			send_far_point();

		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: write_limit(cnt_t'($urandom_range(1, 8)));
				1: write_limit(cnt_t'($urandom_range(9, 300)));
				2: write_limit(MAX_ITER_RST);
				default: write_limit(cnt_t'($urandom_range(300, 600)));
			endcase
			no_gaps = (ph == 5);
			repeat (52) begin
				case ($urandom_range(0, 9))
					0: begin
						re = word_t'($urandom);
						im = word_t'($urandom);
					end
					1: begin
						// fine detail near the origin
						re = word_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
						im = word_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
					end
					default: begin
						// the interesting region, |c| parts up to 2.5
						re = word_t'($urandom_range(0, 32'd1342177280)) - ONE * 5 / 2;
						im = word_t'($urandom_range(0, 32'd1342177280)) - ONE * 5 / 2;
					end
				endcase
				send_point(re, im);
			end
		end
		no_gaps = 1'b0;

		@(negedge clk);
		in_valid = 1'b0;
		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d points, %0d escaping, over %0d limit writes incl. 0, 1, 65535",
			board.points, board.escapes, limit_writes);
		$display("%0d mismatches", board.mismatches);
		if (board.mismatches == 0 && board.awaited.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> filelist.f
hdl/tce_pkg.sv
hdl/tce_front.sv
hdl/tce_queue.sv
hdl/tce_iter.sv
hdl/tricorn_escape_time.sv
bench/tricorn_escape_time_tb.sv
